/* hw/rtl/swtt_pkg.sv */
// Package for the step-wise thermal target evaluator.
// Holds field widths, request/response/config types and register and trend codes.
// Used by every module under hw/rtl.
package swtt_pkg;

  localparam int TEMP_W        = 19;
  localparam int STATE_BITS    = 8;
  localparam int OFFSET_W      = 16;
  localparam int NUM_TRIPS_W   = 3;
  localparam int TRIP_IDX_W    = 2;
  localparam int TREND_W       = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 19;
  localparam int DEF_MAX_TRIPS = 4;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [STATE_BITS-1:0]    state_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  localparam cfg_idx_t CFG_TRIP_LEVEL_0  = 3'd0;
  localparam cfg_idx_t CFG_TRIP_LEVEL_1  = 3'd1;
  localparam cfg_idx_t CFG_TRIP_LEVEL_2  = 3'd2;
  localparam cfg_idx_t CFG_TRIP_LEVEL_3  = 3'd3;
  localparam cfg_idx_t CFG_NUM_TRIPS     = 3'd4;
  localparam cfg_idx_t CFG_TREND_FROM_SENSOR = 3'd5;
  localparam cfg_idx_t CFG_HAS_HYST      = 3'd6;
  localparam cfg_idx_t CFG_TEMP_OFFSET   = 3'd7;

  localparam logic [TREND_W-1:0] TREND_STABLE     = 3'd0;
  localparam logic [TREND_W-1:0] TREND_RAISING    = 3'd1;
  localparam logic [TREND_W-1:0] TREND_DROPPING   = 3'd2;
  localparam logic [TREND_W-1:0] TREND_RAISE_FULL = 3'd3;
  localparam logic [TREND_W-1:0] TREND_DROP_FULL  = 3'd4;

  typedef struct packed {
    temp_t                   zone_temp;
    logic [TRIP_IDX_W-1:0]   trip_index;
    logic [TREND_W-1:0]      trend;
    state_t                  device_state;
    logic                    device_state_unknown;
    state_t                  current_target;
    logic                    current_target_none;
    state_t                  lower_limit;
    state_t                  upper_limit;
  } req_t;

  typedef struct packed {
    state_t target_state;
    logic   update;
  } rsp_t;

  typedef struct packed {
    logic [NUM_TRIPS_W-1:0] num_trips;
    logic                   trend_from_sensor;
    logic                   has_hyst;
    logic [OFFSET_W-1:0]    temp_offset;
  } cfg_t;

endpackage

/* hw/rtl/step_wise_thermal_target_top.sv */
// Top level of the step-wise thermal target evaluator.
// Instantiates swtt_cfg_regs and swtt_eval; depends on swtt_pkg.
//
// Usage: the request channel (req_valid, req_stall, req_data) carries one
// evaluation request per transfer, and the response channel (rsp_valid,
// rsp_stall, rsp_data) returns exactly one response per request, in order.
// A transfer happens on a rising edge where valid is high and stall is low.
// The request is captured in an input register; the evaluation is one pass of
// short logic into the response register, which takes the response when the
// input register moves on and holds it until it transfers out.
// One request per cycle is sustained while the response side does not stall.
// When rsp_stall holds the response register, one more request is still taken
// into the input register, and req_stall rises once both stages are full.
// Configuration registers must be written over cfg_valid/cfg_ready, cfg_index
// and cfg_data only while no request is in flight; the block does not enforce
// it. cfg_ready is always high. Synchronous reset empties both stages and sets
// all configuration registers to zero.
module step_wise_thermal_target_top #(
  parameter int MAX_TRIPS = swtt_pkg::DEF_MAX_TRIPS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  swtt_pkg::req_t                  req_data,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output swtt_pkg::rsp_t                  rsp_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  swtt_pkg::cfg_idx_t              cfg_index,
  input  logic [swtt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import swtt_pkg::*;

  cfg_t  cfg;
  temp_t trip_level [MAX_TRIPS];
  logic  s1_valid;
  req_t  s1_req;
  rsp_t  eval_rsp;
  logic  advance;

  swtt_cfg_regs #(.MAX_TRIPS(MAX_TRIPS)) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .trip_level (trip_level)
  );

  swtt_eval #(.MAX_TRIPS(MAX_TRIPS)) u_eval (
    .cfg        (cfg),
    .trip_level (trip_level),
    .req        (s1_req),
    .rsp        (eval_rsp)
  );

  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      s1_req <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      rsp_data <= eval_rsp;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (s1_valid && rsp_valid && rsp_stall))
    else $error("request stalled while a stage was free");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> s1_valid)
    else $error("accepted request not held in input register");

  a_s1_moves_on: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !(rsp_valid && rsp_stall)) |=> rsp_valid)
    else $error("request in input register produced no response");

  a_no_invented_rsp: assert property (@(posedge clk) disable iff (rst)
    (!s1_valid && !(rsp_valid && rsp_stall)) |=> !rsp_valid)
    else $error("response shown without a request behind it");

  a_no_update_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_data.update) |-> (rsp_data.target_state == '0))
    else $error("target state nonzero without update");
`endif

endmodule

/* hw/rtl/swtt_cfg_regs.sv */
// Configuration register file of the step-wise thermal target evaluator.
// Decodes writes on the configuration channel; depends on swtt_pkg.
module swtt_cfg_regs #(
  parameter int MAX_TRIPS = swtt_pkg::DEF_MAX_TRIPS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  swtt_pkg::cfg_idx_t                  cfg_index,
  input  logic [swtt_pkg::CFG_DATA_W-1:0]     cfg_data,
  output swtt_pkg::cfg_t                      cfg,
  output swtt_pkg::temp_t                     trip_level [MAX_TRIPS]
);
  import swtt_pkg::*;

  logic wr;

  assign cfg_ready = 1'b1;
  assign wr = cfg_valid && cfg_ready;

  for (genvar k = 0; k < MAX_TRIPS; k++) begin : g_trip
    always_ff @(posedge clk) begin
      if (rst) begin
        trip_level[k] <= '0;
      end else if (wr && cfg_index == CFG_TRIP_LEVEL_0 + CFG_IDX_W'(k)) begin
        trip_level[k] <= temp_t'(cfg_data[TEMP_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (cfg_index)
        CFG_NUM_TRIPS:         cfg.num_trips         <= cfg_data[NUM_TRIPS_W-1:0];
        CFG_TREND_FROM_SENSOR: cfg.trend_from_sensor <= cfg_data[0];
        CFG_HAS_HYST:          cfg.has_hyst          <= cfg_data[0];
        CFG_TEMP_OFFSET:       cfg.temp_offset       <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/swtt_eval.sv */
// Combinational evaluation of one request: trip search, step and clamp.
// Depends on swtt_pkg; sits between the request and response registers.
module swtt_eval #(
  parameter int MAX_TRIPS = swtt_pkg::DEF_MAX_TRIPS
) (
  input  swtt_pkg::cfg_t   cfg,
  input  swtt_pkg::temp_t  trip_level [MAX_TRIPS],
  input  swtt_pkg::req_t   req,
  output swtt_pkg::rsp_t   rsp
);
  import swtt_pkg::*;

  localparam int SUM_W = TEMP_W + 2;
  localparam logic [NUM_TRIPS_W-1:0] MAX_N = NUM_TRIPS_W'(MAX_TRIPS);

  logic [NUM_TRIPS_W-1:0] n_eff;
  logic signed [SUM_W-1:0] zone_plus_off;
  logic [MAX_TRIPS-1:0]   hit;
  logic                   found;
  logic [TRIP_IDX_W-1:0]  sel;
  logic                   search_ok;
  logic [NUM_TRIPS_W-1:0] res;
  state_t                 dev;
  state_t                 trip_ext;
  state_t                 step_up;
  state_t                 step_down;
  state_t                 target;
  state_t                 clamped;
  logic                   valid;
  logic                   up;

  assign n_eff = (cfg.num_trips > MAX_N) ? MAX_N : cfg.num_trips;
  assign zone_plus_off = $signed({{2{req.zone_temp[TEMP_W-1]}}, req.zone_temp})
                       + $signed({{(SUM_W-OFFSET_W){1'b0}}, cfg.temp_offset});

  for (genvar k = 0; k < MAX_TRIPS; k++) begin : g_cmp
    assign hit[k] = (NUM_TRIPS_W'(k) < n_eff) &&
                    (zone_plus_off > $signed({{2{trip_level[k][TEMP_W-1]}}, trip_level[k]}));
  end

  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int k = 0; k < MAX_TRIPS; k++) begin
      if (hit[k]) begin
        found = 1'b1;
        sel   = TRIP_IDX_W'(k);
      end
    end
  end

  assign search_ok = (n_eff == '0) || (found && sel == req.trip_index);
  assign res = (n_eff == '0) ? '0 : NUM_TRIPS_W'(req.trip_index) + NUM_TRIPS_W'(1);
  assign dev = req.device_state_unknown ? req.lower_limit : req.device_state;
  assign trip_ext = STATE_BITS'(req.trip_index);
  assign step_up = ((dev > trip_ext) ? trip_ext : dev) + STATE_BITS'(1);
  assign step_down = (req.current_target == '0) ? '0
                   : req.current_target - STATE_BITS'(1);

  always_comb begin
    valid = 1'b0;
    up    = 1'b0;
    if (cfg.trend_from_sensor) begin
      case (req.trend)
        TREND_RAISING: begin
          valid = search_ok;
          up    = 1'b1;
        end
        TREND_DROPPING: begin
          valid = 1'b1;
        end
        default: ;
      endcase
    end else begin
      valid = search_ok;
      up    = !(STATE_BITS'(res) < dev);
    end
    if (!up && req.current_target_none) begin
      valid = 1'b0;
    end
  end

  assign target  = up ? step_up : step_down;
  assign clamped = (target < req.lower_limit) ?
                   ((req.lower_limit > req.upper_limit) ? req.upper_limit : req.lower_limit) :
                   ((target > req.upper_limit) ? req.upper_limit : target);

  assign rsp.update       = valid;
  assign rsp.target_state = valid ? clamped : '0;

endmodule
